// ===== src/dmp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared constants, types and helpers of the depth min-pool preview block.
// ----------------------------------------------------------------------------
package dmp_pkg;

  // line store depth and input fixed-point format
  localparam int MAX_PREVIEW_WIDTH   = 1920;
  localparam int DEPTH_FRACTION_BITS = 8;

  localparam int SAMPLE_W = 32;
  localparam int MIN_W    = SAMPLE_W + 1;       // valid bit above the sample
  localparam int IDX_W    = (MAX_PREVIEW_WIDTH > 1) ? $clog2(MAX_PREVIEW_WIDTH) : 1;
  localparam int POS_W    = 12;
  localparam int FS_W     = 16;
  localparam int GRAY_W   = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // scaler datapath: numerator is sample * 255, divisor is full scale << fraction
  localparam int NUM_W = SAMPLE_W + GRAY_W;
  localparam int DSH_W = FS_W + DEPTH_FRACTION_BITS + GRAY_W;
  localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int STEP_W = 4;                    // counts quotient bits 8 down to 0

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 2'd2;

  localparam logic [POS_W-1:0] FRAME_WIDTH_RESET  = 12'd3840;
  localparam logic [POS_W-1:0] FRAME_HEIGHT_RESET = 12'd2160;
  localparam logic [FS_W-1:0]  FULL_SCALE_RESET   = 16'd8192;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_SCALE,
    ST_EMIT
  } dmp_state_t;

  // request into the scaler
  typedef struct packed {
    logic [MIN_W-1:0] minimum;
    logic             frame_last;
  } scl_req_t;

  // result out of the scaler
  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              frame_last;
  } scl_res_t;

  // minimum of two tagged samples, an untagged one never wins
  function automatic logic [MIN_W-1:0] min33(input logic [MIN_W-1:0] a,
                                             input logic [MIN_W-1:0] b);
    logic [MIN_W-1:0] res;
    if (!a[SAMPLE_W]) begin
      res = b;
    end else if (!b[SAMPLE_W]) begin
      res = a;
    end else if ($signed(b[SAMPLE_W-1:0]) < $signed(a[SAMPLE_W-1:0])) begin
      res = b;
    end else begin
      res = a;
    end
    return res;
  endfunction

endpackage

// ===== src/dmp_line_store.sv =====
// ----------------------------------------------------------------------------
// dmp_line_store
// Half-width line memory holding the pair minima of the upper row of each
// 2x2 block. One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dmp_line_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [dmp_pkg::IDX_W-1:0]  wr_addr,
  input  logic [dmp_pkg::MIN_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [dmp_pkg::IDX_W-1:0]  rd_addr,
  output logic [dmp_pkg::MIN_W-1:0]  rd_data
);
  import dmp_pkg::*;

  logic [MIN_W-1:0] mem [MAX_PREVIEW_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/dmp_scaler.sv =====
// ----------------------------------------------------------------------------
// dmp_scaler
// Maps a block minimum to a gray byte: floor(min * 255 / full_scale) with
// saturation, by restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dmp_scaler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  dmp_pkg::scl_req_t         req,
  input  logic [dmp_pkg::FS_W-1:0]  full_scale,
  output logic                      busy,
  output logic                      res_valid,
  output dmp_pkg::scl_res_t         res
);
  import dmp_pkg::*;

  logic [CMP_W-1:0]  rem;
  logic [CMP_W-1:0]  dsh;
  logic [GRAY_W:0]   quo;
  logic [STEP_W-1:0] step;
  logic              last;

  logic              positive;
  logic [CMP_W-1:0]  samp_ext;
  logic [CMP_W-1:0]  num;
  logic [FS_W-1:0]   fs_eff;
  logic [CMP_W-1:0]  div_top;
  logic              fits;

  // numerator: positive minimum times 255, zero otherwise
  assign positive = req.minimum[SAMPLE_W] && !req.minimum[SAMPLE_W-1]
                    && (req.minimum[SAMPLE_W-1:0] != '0);
  assign samp_ext = CMP_W'(req.minimum[SAMPLE_W-1:0]);
  assign num      = positive ? ((samp_ext << GRAY_W) - samp_ext) : '0;

  // divisor aligned to the saturation bit; zero full scale acts as one
  assign fs_eff  = (full_scale == '0) ? FS_W'(1) : full_scale;
  assign div_top = CMP_W'(fs_eff) << (DEPTH_FRACTION_BITS + GRAY_W);

  assign fits = rem >= dsh;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      step      <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      res_valid <= 1'b0;
      step      <= STEP_W'(GRAY_W);
    end else if (busy) begin
      if (step == '0) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end else begin
        step <= step - STEP_W'(1);
      end
    end
  end

  // datapath, top quotient bit flags saturation
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= div_top;
      quo  <= '0;
      last <= req.frame_last;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[GRAY_W-1:0], fits};
      dsh <= dsh >> 1;
    end
  end

  assign res.gray       = quo[GRAY_W] ? {GRAY_W{1'b1}} : quo[GRAY_W-1:0];
  assign res.frame_last = last;

endmodule

// ===== src/depth_min_pool_preview.sv =====
// ----------------------------------------------------------------------------
// depth_min_pool_preview
// 2x2 minimum pooling of a raster depth stream into an 8-bit preview.
// Timing: an item that yields no byte leaves the input open; an item that
// yields a byte closes the input through the merge, scale and emit states,
// until its byte is loaded into the output register, which waits while the
// output stalls. The 9-step restoring divider sets the scale state's length.
// Reset (synchronous, rst high): registers to their defaults, position zero,
// pair minimum not valid; the line store holds no reset value.
// ----------------------------------------------------------------------------
module depth_min_pool_preview (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [dmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmp_pkg::CFG_W-1:0]         cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,  // depth_sample[31:0]
  input  logic                              s_tuser,  // depth_finite
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,  // gray_level[7:0]
  output logic                              m_tlast   // frame_last
);
  import dmp_pkg::*;

  // configuration registers
  logic [POS_W-1:0] frame_width;
  logic [POS_W-1:0] frame_height;
  logic [FS_W-1:0]  full_scale_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RESET;
      frame_height     <= FRAME_HEIGHT_RESET;
      full_scale_depth <= FULL_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width      <= cfg_data[POS_W-1:0];
        REG_FRAME_HEIGHT: frame_height     <= cfg_data[POS_W-1:0];
        REG_FULL_SCALE:   full_scale_depth <= cfg_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // state and position
  dmp_state_t        state, state_next;
  logic [POS_W-1:0]  col, row;
  logic [IDX_W-1:0]  pair_idx;
  logic [MIN_W-1:0]  running_pair_min;
  logic [MIN_W-1:0]  pend_pair;
  logic              pend_use_row;
  logic              pend_last;

  logic              accept;
  logic [POS_W-1:0]  w_eff, h_eff;
  logic              last_col, last_row;
  logic [MIN_W-1:0]  cur;
  logic [MIN_W-1:0]  pair_new;
  logic              pair_done;
  logic              store_pair;
  logic              emit_now;

  logic [MIN_W-1:0]  row_min;
  scl_req_t          scl_req;
  scl_res_t          scl_res;
  logic              scl_start;
  logic              scl_busy;
  logic              scl_valid;
  logic              out_load;

  // position decode of the item at the port
  assign accept    = s_tvalid && s_tready;
  assign w_eff     = (frame_width == '0) ? POS_W'(1) : frame_width;
  assign h_eff     = (frame_height == '0) ? POS_W'(1) : frame_height;
  assign last_col  = col >= (w_eff - POS_W'(1));
  assign last_row  = row >= (h_eff - POS_W'(1));
  assign cur       = s_tuser ? {1'b1, s_tdata} : '0;
  assign pair_new  = col[0] ? min33(running_pair_min, cur) : cur;
  assign pair_done = col[0] || last_col;
  assign store_pair = pair_done && !row[0] && !last_row;
  assign emit_now  = pair_done && !store_pair;

  // counters and pair minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      col              <= '0;
      row              <= '0;
      pair_idx         <= '0;
      running_pair_min <= '0;
    end else if (accept) begin
      running_pair_min <= pair_new;
      if (last_col) begin
        col      <= '0;
        pair_idx <= '0;
        row      <= last_row ? '0 : row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
        if (col[0]) begin
          pair_idx <= (pair_idx == IDX_W'(MAX_PREVIEW_WIDTH - 1)) ? '0
                                                                   : pair_idx + IDX_W'(1);
        end
      end
    end
  end

  // block data held while the byte is computed
  always_ff @(posedge clk) begin
    if (accept && emit_now) begin
      pend_pair    <= pair_new;
      pend_use_row <= row[0];
      pend_last    <= last_col && last_row;
    end
  end

  dmp_line_store u_line_store (
    .clk     (clk),
    .wr_en   (accept && store_pair),
    .wr_addr (pair_idx),
    .wr_data (pair_new),
    .rd_en   (accept && emit_now),
    .rd_addr (pair_idx),
    .rd_data (row_min)
  );

  // merge the stored upper pair with the lower pair
  assign scl_req.minimum    = pend_use_row ? min33(row_min, pend_pair) : pend_pair;
  assign scl_req.frame_last = pend_last;

  dmp_scaler u_scaler (
    .clk        (clk),
    .rst        (rst),
    .start      (scl_start),
    .req        (scl_req),
    .full_scale (full_scale_depth),
    .busy       (scl_busy),
    .res_valid  (scl_valid),
    .res        (scl_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && emit_now) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: state_next = ST_SCALE;
      ST_SCALE: begin
        if (scl_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = 1'b0;
    scl_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:  s_tready  = 1'b1;
      ST_MERGE: scl_start = 1'b1;
      ST_SCALE: ;
      ST_EMIT:  out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= scl_res.gray;
      m_tlast <= scl_res.frame_last;
    end
  end

  // checks
  a_idle_scaler_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !scl_busy)
    else $error("scaler busy while input is open");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  a_emit_item_starts_merge: assert property (@(posedge clk) disable iff (rst)
    (accept && emit_now) |=> (state == ST_MERGE))
    else $error("block result item not taken to merge");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    scl_start |=> (scl_busy && !scl_valid))
    else $error("scaler did not start");

endmodule
